// ===== src/bsg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsg_pkg
// Shared types and constants of the multi-axis Bresenham step generator.
// ----------------------------------------------------------------------------
package bsg_pkg;

  localparam int AXES       = 6;
  localparam int MAX_AXES   = 6;
  localparam int COUNT_BITS = 32;
  localparam int STEP_BITS  = 32;
  localparam int POS_BITS   = 32;
  localparam int TICK_BITS  = 16;
  localparam int QUERY_BITS = 3;

  localparam logic [MAX_AXES-1:0] AXIS_MASK = MAX_AXES'((1 << AXES) - 1);

  typedef enum logic [1:0] {
    CMD_LINE    = 2'd0,
    CMD_SEGMENT = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic load;
    logic run;
    logic clear;
  } lane_ctrl_t;

  typedef struct packed {
    logic [MAX_AXES-1:0]        step_pulses;
    logic [MAX_AXES-1:0]        dir_bits;
    logic                       segment_done;
    logic                       idle;
    logic signed [POS_BITS-1:0] axis_pos;
  } result_t;

endpackage
`default_nettype wire

// ===== src/bsg_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsg_lane
// One axis: step count, error accumulator and position of that axis.
// ----------------------------------------------------------------------------
module bsg_lane (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire bsg_pkg::lane_ctrl_t               ctrl_i,
  input  wire logic [bsg_pkg::COUNT_BITS-1:0]    count_i,
  input  wire logic [bsg_pkg::COUNT_BITS-1:0]    total_d_i,
  input  wire logic [bsg_pkg::COUNT_BITS-1:0]    total_q_i,
  input  wire logic                              dir_i,
  output logic                                   step_o,
  output logic [bsg_pkg::POS_BITS-1:0]           pos_d_o
);

  logic [bsg_pkg::COUNT_BITS-1:0] count_q;
  logic [bsg_pkg::COUNT_BITS:0]   err_q, err_d, sum;
  logic [bsg_pkg::POS_BITS-1:0]   pos_q;
  logic                           hit;

  assign sum    = err_q + {1'b0, count_q};
  assign hit    = sum > {1'b0, total_q_i};
  assign step_o = ctrl_i.run && hit;

  always_comb begin
    err_d = err_q;
    if (ctrl_i.load) begin
      err_d = {1'b0, total_d_i >> 1};
    end else if (ctrl_i.run) begin
      err_d = hit ? sum - {1'b0, total_q_i} : sum;
    end
  end

  always_comb begin
    pos_d_o = pos_q;
    if (ctrl_i.clear) begin
      pos_d_o = '0;
    end else if (step_o) begin
      pos_d_o = dir_i ? pos_q - 1'b1 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      err_q   <= '0;
      pos_q   <= '0;
    end else begin
      if (ctrl_i.load) begin
        count_q <= count_i;
      end
      err_q <= err_d;
      pos_q <= pos_d_o;
    end
  end

endmodule
`default_nettype wire

// ===== src/bsg_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsg_merge
// Gathers the lane step bits and selects the queried axis position.
// ----------------------------------------------------------------------------
module bsg_merge (
  input  wire logic [bsg_pkg::AXES-1:0]          steps_i,
  input  wire logic [bsg_pkg::POS_BITS-1:0]      pos_i [bsg_pkg::AXES],
  input  wire logic [bsg_pkg::QUERY_BITS-1:0]    query_i,
  output logic [bsg_pkg::MAX_AXES-1:0]           pulses_o,
  output logic [bsg_pkg::POS_BITS-1:0]           pos_o
);

  localparam logic [bsg_pkg::QUERY_BITS-1:0] QUERY_LIMIT = bsg_pkg::QUERY_BITS'(bsg_pkg::AXES);

  logic [bsg_pkg::POS_BITS-1:0] pos_all [bsg_pkg::MAX_AXES];

  always_comb begin
    pulses_o = '0;
    for (int i = 0; i < bsg_pkg::MAX_AXES; i++) begin
      pos_all[i] = '0;
    end
    for (int i = 0; i < bsg_pkg::AXES; i++) begin
      pulses_o[i] = steps_i[i];
      pos_all[i]  = pos_i[i];
    end
    pos_o = '0;
    if (query_i < QUERY_LIMIT) begin
      pos_o = pos_all[query_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/multi_axis_bresenham_step_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_axis_bresenham_step_generator
// Six-axis Bresenham step pulse generator with one lane per axis.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command word:
//   load line, load segment, step tick or clear positions. Every
//   accepted word yields exactly one result word on the output channel
//   (out_valid_o / out_stall_i).
//   The result goes into the output register, or the skid register if stalled.
//   Throughput: one word per cycle while in_stall_o is low; all axis lanes add,
//   compare and subtract in parallel in the cycle of acceptance.
//   Step bits computed on a tick are reported by the following tick.
//   A two-entry output buffer (output register plus skid register) keeps
//   input acceptance going while one result waits; in_stall_o rises only
//   when both entries are full, and the output payload holds while the
//   receiver stalls.
//   Reset clears counts, errors, positions, the segment and both buffer
//   valid flags; the block takes words as soon as reset is released.
// ----------------------------------------------------------------------------
module multi_axis_bresenham_step_generator (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic [1:0]                            cmd_i,
  input  wire logic [bsg_pkg::STEP_BITS-1:0]         axis0_steps_i,
  input  wire logic [bsg_pkg::STEP_BITS-1:0]         axis1_steps_i,
  input  wire logic [bsg_pkg::STEP_BITS-1:0]         axis2_steps_i,
  input  wire logic [bsg_pkg::STEP_BITS-1:0]         axis3_steps_i,
  input  wire logic [bsg_pkg::STEP_BITS-1:0]         axis4_steps_i,
  input  wire logic [bsg_pkg::STEP_BITS-1:0]         axis5_steps_i,
  input  wire logic [bsg_pkg::MAX_AXES-1:0]          dir_mask_i,
  input  wire logic [bsg_pkg::TICK_BITS-1:0]         segment_ticks_i,
  input  wire logic                                  is_dwell_i,
  input  wire logic [bsg_pkg::QUERY_BITS-1:0]        query_axis_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [bsg_pkg::MAX_AXES-1:0]               step_pulses_o,
  output logic [bsg_pkg::MAX_AXES-1:0]               dir_bits_o,
  output logic                                       segment_done_o,
  output logic                                       idle_o,
  output logic signed [bsg_pkg::POS_BITS-1:0]        axis_pos_o
);

  localparam logic [bsg_pkg::TICK_BITS-1:0] TICK_ONE = bsg_pkg::TICK_BITS'(1);

  logic [bsg_pkg::STEP_BITS-1:0]  steps_in [bsg_pkg::MAX_AXES];
  logic [bsg_pkg::COUNT_BITS-1:0] total_q, total_d;
  logic [bsg_pkg::MAX_AXES-1:0]   dirs_q, dirs_d;
  logic [bsg_pkg::TICK_BITS-1:0]  ticks_q, ticks_d;
  logic                           active_q, active_d;
  logic                           dwell_q, dwell_d;
  logic [bsg_pkg::MAX_AXES-1:0]   pending_q, pending_d;

  logic                           accept, out_take;
  logic                           is_line, is_seg, is_tick, is_clear, run;
  bsg_pkg::lane_ctrl_t            lane_ctrl;
  logic [bsg_pkg::AXES-1:0]       lane_step;
  logic [bsg_pkg::POS_BITS-1:0]   lane_pos [bsg_pkg::AXES];
  logic [bsg_pkg::MAX_AXES-1:0]   run_pulses;
  logic [bsg_pkg::POS_BITS-1:0]   sel_pos;
  bsg_pkg::result_t               res, out_q, skid_q;
  logic                           out_valid_q, skid_valid_q;

  assign steps_in[0] = axis0_steps_i;
  assign steps_in[1] = axis1_steps_i;
  assign steps_in[2] = axis2_steps_i;
  assign steps_in[3] = axis3_steps_i;
  assign steps_in[4] = axis4_steps_i;
  assign steps_in[5] = axis5_steps_i;

  assign accept   = in_valid_i && !skid_valid_q;
  assign out_take = out_valid_q && !out_stall_i;

  always_comb begin
    is_line  = 1'b0;
    is_seg   = 1'b0;
    is_tick  = 1'b0;
    is_clear = 1'b0;
    case (bsg_pkg::cmd_e'(cmd_i))
      bsg_pkg::CMD_LINE:    is_line  = accept;
      bsg_pkg::CMD_SEGMENT: is_seg   = accept;
      bsg_pkg::CMD_TICK:    is_tick  = accept;
      bsg_pkg::CMD_CLEAR:   is_clear = accept;
      default:              is_clear = 1'b0;
    endcase
  end

  assign run             = is_tick && active_q && !dwell_q;
  assign lane_ctrl.load  = is_line;
  assign lane_ctrl.run   = run;
  assign lane_ctrl.clear = is_clear;

  always_comb begin
    total_d = '0;
    for (int i = 0; i < bsg_pkg::AXES; i++) begin
      if (steps_in[i][bsg_pkg::COUNT_BITS-1:0] > total_d) begin
        total_d = steps_in[i][bsg_pkg::COUNT_BITS-1:0];
      end
    end
  end

  for (genvar g = 0; g < bsg_pkg::AXES; g++) begin : g_lane
    bsg_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (lane_ctrl),
      .count_i   (steps_in[g][bsg_pkg::COUNT_BITS-1:0]),
      .total_d_i (total_d),
      .total_q_i (total_q),
      .dir_i     (dirs_q[g]),
      .step_o    (lane_step[g]),
      .pos_d_o   (lane_pos[g])
    );
  end

  bsg_merge u_merge (
    .steps_i  (lane_step),
    .pos_i    (lane_pos),
    .query_i  (query_axis_i),
    .pulses_o (run_pulses),
    .pos_o    (sel_pos)
  );

  always_comb begin
    ticks_d   = ticks_q;
    active_d  = active_q;
    dwell_d   = dwell_q;
    pending_d = pending_q;
    dirs_d    = dirs_q;
    res.step_pulses  = '0;
    res.segment_done = 1'b0;
    res.idle         = 1'b0;
    if (is_line) begin
      dirs_d = dir_mask_i & bsg_pkg::AXIS_MASK;
    end
    if (is_seg) begin
      ticks_d  = segment_ticks_i;
      active_d = segment_ticks_i != '0;
      dwell_d  = is_dwell_i;
    end
    if (is_tick) begin
      res.step_pulses = pending_q;
      pending_d       = '0;
      if (active_q) begin
        ticks_d = ticks_q - 1'b1;
        if (!dwell_q) begin
          pending_d = run_pulses;
        end
        if (ticks_q == TICK_ONE) begin
          active_d         = 1'b0;
          res.segment_done = 1'b1;
        end
      end else begin
        res.idle = 1'b1;
      end
    end
    res.dir_bits = dirs_d;
    res.axis_pos = sel_pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      dirs_q    <= '0;
      ticks_q   <= '0;
      active_q  <= 1'b0;
      dwell_q   <= 1'b0;
      pending_q <= '0;
    end else begin
      if (is_line) begin
        total_q <= total_d;
      end
      dirs_q    <= dirs_d;
      ticks_q   <= ticks_d;
      active_q  <= active_d;
      dwell_q   <= dwell_d;
      pending_q <= pending_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign in_stall_o     = skid_valid_q;
  assign out_valid_o    = out_valid_q;
  assign step_pulses_o  = out_q.step_pulses;
  assign dir_bits_o     = out_q.dir_bits;
  assign segment_done_o = out_q.segment_done;
  assign idle_o         = out_q.idle;
  assign axis_pos_o     = out_q.axis_pos;

endmodule
`default_nettype wire

// ===== src/bsg_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsg_checker
// Port-level checks of the step generator, bound to its top level.
// ----------------------------------------------------------------------------
module bsg_checker (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_stall_o,
  input  wire logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  input  wire logic [bsg_pkg::MAX_AXES-1:0]       step_pulses_o,
  input  wire logic [bsg_pkg::MAX_AXES-1:0]       dir_bits_o,
  input  wire logic                               segment_done_o,
  input  wire logic                               idle_o,
  input  wire logic signed [bsg_pkg::POS_BITS-1:0] axis_pos_o
);

  a_idle_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && idle_o |-> !segment_done_o)
    else $error("idle and segment_done both set");

  a_axis_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((step_pulses_o | dir_bits_o) & ~bsg_pkg::AXIS_MASK) == '0)
    else $error("step or direction bit beyond configured axes");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(step_pulses_o)
      && $stable(dir_bits_o) && $stable(axis_pos_o))
    else $error("stalled output word changed");

endmodule

bind multi_axis_bresenham_step_generator bsg_checker u_bsg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .step_pulses_o  (step_pulses_o),
  .dir_bits_o     (dir_bits_o),
  .segment_done_o (segment_done_o),
  .idle_o         (idle_o),
  .axis_pos_o     (axis_pos_o)
);
`default_nettype wire

// ===== verif/bsg_step_checker.sv =====
// ----------------------------------------------------------------------------
// bsg_step_checker
// Watches both channels of the step generator. It keeps its own copy of the
// line, segment and axis state, works out the result of every accepted
// command word, and compares each accepted result word with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module bsg_step_checker (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire logic                                           in_valid_i,
  input  wire logic                                           in_stall_i,
  input  wire logic [1:0]                                     cmd_i,
  input  wire logic [bsg_pkg::MAX_AXES-1:0][bsg_pkg::STEP_BITS-1:0] steps_i,
  input  wire logic [bsg_pkg::MAX_AXES-1:0]                   dir_mask_i,
  input  wire logic [bsg_pkg::TICK_BITS-1:0]                  segment_ticks_i,
  input  wire logic                                           is_dwell_i,
  input  wire logic [bsg_pkg::QUERY_BITS-1:0]                 query_axis_i,
  input  wire logic                                           out_valid_i,
  input  wire logic                                           out_stall_i,
  input  wire logic [bsg_pkg::MAX_AXES-1:0]                   step_pulses_i,
  input  wire logic [bsg_pkg::MAX_AXES-1:0]                   dir_bits_i,
  input  wire logic                                           segment_done_i,
  input  wire logic                                           idle_i,
  input  wire logic signed [bsg_pkg::POS_BITS-1:0]            axis_pos_i,
  output int unsigned                                         results_owed_o,
  output int unsigned                                         mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [bsg_pkg::COUNT_BITS-1:0] line_counts [bsg_pkg::MAX_AXES];
  logic [bsg_pkg::COUNT_BITS-1:0] line_total;
  logic [bsg_pkg::COUNT_BITS:0]   err_acc [bsg_pkg::MAX_AXES];
  logic [bsg_pkg::MAX_AXES-1:0]   line_dirs;
  logic [bsg_pkg::MAX_AXES-1:0]   pending_steps;
  logic [bsg_pkg::POS_BITS-1:0]   axis_position [bsg_pkg::MAX_AXES];
  logic [bsg_pkg::TICK_BITS-1:0]  ticks_left;
  logic                           seg_active;
  logic                           seg_dwell;
  bsg_pkg::result_t               owed_results [$];
  int unsigned                    mismatches = 0;
  int unsigned                    results_seen = 0;

  task automatic advance_axes(output logic [bsg_pkg::MAX_AXES-1:0] fired);
    logic [bsg_pkg::COUNT_BITS+1:0] sum;
    fired = '0;
    for (int a = 0; a < bsg_pkg::AXES; a++) begin
      sum = err_acc[a] + line_counts[a];
      if (sum > line_total) begin
        sum = sum - line_total;
        fired[a] = 1'b1;
        if (line_dirs[a]) begin
          axis_position[a] = axis_position[a] - 1'b1;
        end else begin
          axis_position[a] = axis_position[a] + 1'b1;
        end
      end
      err_acc[a] = sum[bsg_pkg::COUNT_BITS:0];
    end
  endtask

  task automatic predict_result(input bsg_pkg::cmd_e cmd, output bsg_pkg::result_t r);
    logic [bsg_pkg::COUNT_BITS-1:0] widest;
    r = '0;
    widest = '0;
    case (cmd)
      bsg_pkg::CMD_LINE: begin
        for (int a = 0; a < bsg_pkg::MAX_AXES; a++) begin
          line_counts[a] = (a < bsg_pkg::AXES) ? steps_i[a][bsg_pkg::COUNT_BITS-1:0] : '0;
          if (line_counts[a] > widest) begin
            widest = line_counts[a];
          end
        end
        line_total = widest;
        for (int a = 0; a < bsg_pkg::MAX_AXES; a++) begin
          err_acc[a] = {1'b0, widest >> 1};
        end
        line_dirs = dir_mask_i & bsg_pkg::AXIS_MASK;
      end
      bsg_pkg::CMD_SEGMENT: begin
        ticks_left = segment_ticks_i;
        seg_active = (segment_ticks_i != '0);
        seg_dwell  = is_dwell_i;
      end
      bsg_pkg::CMD_TICK: begin
        r.step_pulses = pending_steps;
        pending_steps = '0;
        if (seg_active) begin
          ticks_left = ticks_left - 1'b1;
          if (!seg_dwell) begin
            advance_axes(pending_steps);
          end
          if (ticks_left == '0) begin
            seg_active = 1'b0;
            r.segment_done = 1'b1;
          end
        end else begin
          r.idle = 1'b1;
        end
      end
      bsg_pkg::CMD_CLEAR: begin
        for (int a = 0; a < bsg_pkg::MAX_AXES; a++) begin
          axis_position[a] = '0;
        end
      end
      default: begin
        r.idle = 1'b0;
      end
    endcase
    r.dir_bits = line_dirs;
    if (query_axis_i < bsg_pkg::AXES) begin
      r.axis_pos = axis_position[query_axis_i];
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bsg_pkg::result_t want;
    bsg_pkg::result_t got;
    logic             bad;
    if (!rst_ni) begin
      for (int a = 0; a < bsg_pkg::MAX_AXES; a++) begin
        line_counts[a]   = '0;
        err_acc[a]       = '0;
        axis_position[a] = '0;
      end
      line_total    = '0;
      line_dirs     = '0;
      pending_steps = '0;
      ticks_left    = '0;
      seg_active    = 1'b0;
      seg_dwell     = 1'b0;
      owed_results.delete();
      results_owed_o   <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.step_pulses  = step_pulses_i;
        got.dir_bits     = dir_bits_i;
        got.segment_done = segment_done_i;
        got.idle         = idle_i;
        got.axis_pos     = axis_pos_i;
        results_seen++;
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result word %0d arrived with nothing outstanding: %p",
                     results_seen, got);
          end
        end else begin
          want = owed_results.pop_front();
          bad = (got.step_pulses !== want.step_pulses) ||
                (got.dir_bits !== want.dir_bits) ||
                (got.segment_done !== want.segment_done) ||
                (got.idle !== want.idle) ||
                (got.axis_pos !== want.axis_pos);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result word %0d mismatch", results_seen);
              $display("  exp: pulses %h dir %h done %b idle %b pos %0d",
                       want.step_pulses, want.dir_bits, want.segment_done,
                       want.idle, want.axis_pos);
              $display("  got: pulses %h dir %h done %b idle %b pos %0d",
                       got.step_pulses, got.dir_bits, got.segment_done,
                       got.idle, got.axis_pos);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_result(bsg_pkg::cmd_e'(cmd_i), want);
        owed_results.push_back(want);
      end
      results_owed_o   <= owed_results.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ===== verif/tb_multi_axis_bresenham_step_generator.sv =====
// ----------------------------------------------------------------------------
// tb_multi_axis_bresenham_step_generator
// Drives command words into the step generator: a directed opening over the
// edge cases of lines, segments, dwell, ticks and queries, then randomized
// line/segment/tick sequences mixed with noise words, under three idling
// phases and a full drain in the middle. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_multi_axis_bresenham_step_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_WORDS = 1050;
  localparam int PHASE_WORDS = TOTAL_WORDS / 3;
  localparam int QUIET_LIMIT = 2000;

  typedef logic [bsg_pkg::MAX_AXES-1:0][bsg_pkg::STEP_BITS-1:0] line_steps_t;

  typedef struct {
    bsg_pkg::cmd_e                      cmd;
    line_steps_t                        steps;
    logic [bsg_pkg::MAX_AXES-1:0]       dirs;
    logic [bsg_pkg::TICK_BITS-1:0]      ticks;
    logic                               dwell;
    logic [bsg_pkg::QUERY_BITS-1:0]     query;
  } command_word_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  bsg_pkg::cmd_e                      cmd = bsg_pkg::CMD_TICK;
  line_steps_t                        axis_steps = '0;
  logic [bsg_pkg::MAX_AXES-1:0]       dir_mask = '0;
  logic [bsg_pkg::TICK_BITS-1:0]      segment_ticks = '0;
  logic                               is_dwell = 1'b0;
  logic [bsg_pkg::QUERY_BITS-1:0]     query_axis = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [bsg_pkg::MAX_AXES-1:0]       step_pulses;
  logic [bsg_pkg::MAX_AXES-1:0]       dir_bits;
  logic                               segment_done;
  logic                               idle;
  logic signed [bsg_pkg::POS_BITS-1:0] axis_pos;

  int unsigned results_owed;
  int unsigned mismatch_count;
  int unsigned words_sent = 0;
  int unsigned send_idle_pct = 28;
  int unsigned recv_stall_pct = 82;
  int unsigned quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_axis_bresenham_step_generator i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cmd_i           (cmd),
    .axis0_steps_i   (axis_steps[0]),
    .axis1_steps_i   (axis_steps[1]),
    .axis2_steps_i   (axis_steps[2]),
    .axis3_steps_i   (axis_steps[3]),
    .axis4_steps_i   (axis_steps[4]),
    .axis5_steps_i   (axis_steps[5]),
    .dir_mask_i      (dir_mask),
    .segment_ticks_i (segment_ticks),
    .is_dwell_i      (is_dwell),
    .query_axis_i    (query_axis),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .step_pulses_o   (step_pulses),
    .dir_bits_o      (dir_bits),
    .segment_done_o  (segment_done),
    .idle_o          (idle),
    .axis_pos_o      (axis_pos)
  );

  bsg_step_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .cmd_i            (cmd),
    .steps_i          (axis_steps),
    .dir_mask_i       (dir_mask),
    .segment_ticks_i  (segment_ticks),
    .is_dwell_i       (is_dwell),
    .query_axis_i     (query_axis),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .step_pulses_i    (step_pulses),
    .dir_bits_i       (dir_bits),
    .segment_done_i   (segment_done),
    .idle_i           (idle),
    .axis_pos_i       (axis_pos),
    .results_owed_o   (results_owed),
    .mismatch_count_o (mismatch_count)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [bsg_pkg::STEP_BITS-1:0] pick_count();
    case ($urandom_range(7))
      0:       return '0;
      1:       return $urandom_range(15);
      2, 3:    return $urandom_range(1000);
      4:       return 32'hFFFF_FFFF;
      5:       return $urandom_range(32'hFFFF_FFFF, 32'hFFFF_FF00);
      default: return $urandom;
    endcase
  endfunction

  function automatic line_steps_t pick_line();
    line_steps_t counts;
    for (int a = 0; a < bsg_pkg::MAX_AXES; a++) begin
      counts[a] = pick_count();
    end
    return counts;
  endfunction

  function automatic logic [bsg_pkg::QUERY_BITS-1:0] pick_query();
    if ($urandom_range(15) == 0) begin
      return bsg_pkg::QUERY_BITS'($urandom_range(7, bsg_pkg::AXES));
    end
    return bsg_pkg::QUERY_BITS'($urandom_range(bsg_pkg::AXES - 1));
  endfunction

  function automatic logic [bsg_pkg::MAX_AXES-1:0] pick_dirs();
    return bsg_pkg::MAX_AXES'($urandom);
  endfunction

  function automatic command_word_t noise_word();
    command_word_t w;
    w.cmd   = bsg_pkg::cmd_e'($urandom_range(3));
    w.steps = pick_line();
    w.dirs  = pick_dirs();
    w.ticks = bsg_pkg::TICK_BITS'($urandom);
    w.dwell = 1'($urandom_range(1));
    w.query = bsg_pkg::QUERY_BITS'($urandom_range(7));
    return w;
  endfunction

  function automatic command_word_t bare_word(input bsg_pkg::cmd_e c);
    command_word_t w;
    w       = noise_word();
    w.cmd   = c;
    w.query = pick_query();
    return w;
  endfunction

  function automatic command_word_t line_word(
    input line_steps_t                  counts,
    input logic [bsg_pkg::MAX_AXES-1:0] dirs
  );
    command_word_t w;
    w       = bare_word(bsg_pkg::CMD_LINE);
    w.steps = counts;
    w.dirs  = dirs;
    return w;
  endfunction

  function automatic command_word_t segment_word(
    input logic [bsg_pkg::TICK_BITS-1:0] ticks,
    input logic                          dwell
  );
    command_word_t w;
    w       = bare_word(bsg_pkg::CMD_SEGMENT);
    w.ticks = ticks;
    w.dwell = dwell;
    return w;
  endfunction

  task automatic send_word(input command_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= w.cmd;
    axis_steps    <= w.steps;
    dir_mask      <= w.dirs;
    segment_ticks <= w.ticks;
    is_dwell      <= w.dwell;
    query_axis    <= w.query;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (words_sent == PHASE_WORDS) begin
      send_idle_pct = 82;
      recv_stall_pct <= 28;
    end else if (words_sent == 2 * PHASE_WORDS) begin
      send_idle_pct = 0;
      recv_stall_pct <= 0;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  initial begin : stimulus
    command_word_t w;
    int unsigned   len;
    int unsigned   n;
    int unsigned   pick;
    bit            drained_mid;
    drained_mid = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_word(bare_word(bsg_pkg::CMD_TICK));
    send_word(line_word({bsg_pkg::MAX_AXES{32'hFFFF_FFFF}}, 6'h3F));
    send_word(segment_word(16'd3, 1'b0));
    repeat (4) send_word(bare_word(bsg_pkg::CMD_TICK));
    send_word(line_word('0, 6'h00));
    send_word(segment_word(16'd0, 1'b0));
    send_word(bare_word(bsg_pkg::CMD_TICK));
    send_word(line_word({32'd2, 32'd1, 32'd5, 32'd0, 32'd3, 32'd7}, 6'h2A));
    send_word(segment_word(16'd2, 1'b1));
    repeat (3) send_word(bare_word(bsg_pkg::CMD_TICK));
    send_word(segment_word(16'hFFFF, 1'b0));
    repeat (3) send_word(bare_word(bsg_pkg::CMD_TICK));
    send_word(line_word({32'd9, 32'd0, 32'd4, 32'hFFFF_FFFE, 32'd1, 32'd8}, 6'h15));
    send_word(segment_word(16'd2, 1'b0));
    repeat (2) send_word(bare_word(bsg_pkg::CMD_TICK));
    w = bare_word(bsg_pkg::CMD_TICK);
    w.query = 3'd6;
    send_word(w);
    w = bare_word(bsg_pkg::CMD_CLEAR);
    w.query = 3'd7;
    send_word(w);
    w = bare_word(bsg_pkg::CMD_TICK);
    w.query = 3'd5;
    send_word(w);

    while (words_sent < TOTAL_WORDS) begin
      if ($urandom_range(99) < 85) begin
        send_word(line_word(pick_line(), pick_dirs()));
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        send_word(segment_word(bsg_pkg::TICK_BITS'(len), $urandom_range(5) == 0));
        n = ($urandom_range(7) == 0) ? $urandom_range(len) : len + $urandom_range(2);
        repeat (n) begin
          pick = $urandom_range(59);
          if (pick == 0) begin
            send_word(line_word(pick_line(), pick_dirs()));
          end else if (pick == 1) begin
            send_word(bare_word(bsg_pkg::CMD_CLEAR));
          end else begin
            send_word(bare_word(bsg_pkg::CMD_TICK));
          end
        end
      end else begin
        repeat ($urandom_range(4, 1)) send_word(noise_word());
      end
      if ((!drained_mid && words_sent >= TOTAL_WORDS / 2) || $urandom_range(39) == 0) begin
        drain_results();
        drained_mid = 1'b1;
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
